### sv/cgap_pkg.sv
// ----------------------------------------------------------------------------
// cgap_pkg
// shared types and constants of the controlled gate application core
// ----------------------------------------------------------------------------
`default_nettype none

package cgap_pkg;

  // request kinds
  typedef enum logic [1:0] {
    REQ_LOAD_AMP   = 2'd0,
    REQ_LOAD_GATE  = 2'd1,
    REQ_COMPUTE    = 2'd2,
    REQ_CLEAR_NORM = 2'd3
  } req_kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_QUBIT_COUNT      = 3'd0,
    CFG_TARGET_COUNT     = 3'd1,
    CFG_TARGET_FIRST     = 3'd2,
    CFG_TARGET_SECOND    = 3'd3,
    CFG_CONTROL_MASK     = 3'd4,
    CFG_ANTICONTROL_MASK = 3'd5
  } cfg_reg_t;

  // back end sequencer
  typedef enum logic [2:0] {
    B_IDLE,
    B_ISSUE,
    B_DRAIN,
    B_ROUND,
    B_SQUARE,
    B_NORM
  } back_state_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [15:0]        amp_index;
    logic [1:0]         matrix_row;
    logic [1:0]         matrix_col;
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
  } req_t;

  typedef struct packed {
    logic [15:0]        out_index;
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               passed_through;
    logic [62:0]        norm_sum;
  } rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [62:0]        NORM_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] GATE_ONE = 32'sh4000_0000;

  localparam logic [4:0]  RST_QUBIT_COUNT   = 5'd16;
  localparam logic [1:0]  RST_TARGET_COUNT  = 2'd1;
  localparam logic [3:0]  RST_TARGET_FIRST  = 4'd0;
  localparam logic [3:0]  RST_TARGET_SECOND = 4'd1;

endpackage

`default_nettype wire

### sv/controlled_gate_application_core.sv
// ----------------------------------------------------------------------------
// controlled_gate_application_core
// controlled one or two qubit gate applied to a stored complex state vector
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  request  req_valid / req_ready  req   (req_t)
//  result   rsp_valid / rsp_ready  rsp   (rsp_t)
//  config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  load and clear requests retire as they are popped, in the idle state
//  a compute request fetches its column amplitudes (two for one target,
//  four for two, one on pass-through) through the single amplitude read port
//  one amplitude per cycle, then passes the multiply, round, square stages
//  rst is synchronous; the amplitude and gate stores are not cleared
//  the two entry queue accepts requests while a result waits, until it is full
// ----------------------------------------------------------------------------
`default_nettype none

module controlled_gate_application_core import cgap_pkg::*; #(
  parameter int MAX_QUBITS  = 16,
  parameter int MAX_TARGETS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // command width: kind, pass, last column, row, gate address, index,
  // four replaced indexes and the loaded value
  localparam int AW = MAX_QUBITS;
  localparam int IW = (MAX_QUBITS > 16) ? MAX_QUBITS : 16;
  localparam int CW = 75 + IW + 4 * AW;

  logic          q_push;
  logic          q_pop;
  logic [CW-1:0] q_din;
  logic [CW-1:0] q_dout;
  q_stat_t       q_stat;

  // front: config registers, control test and index replacement
  cgap_front #(
    .MAX_QUBITS  (MAX_QUBITS),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_stat.full),
    .push      (q_push),
    .cmd_out   (q_din)
  );

  // queue decouples classification from execution
  cgap_fifo #(
    .W (CW)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  // back: stores, multiply-accumulate, rounding, norm and result register
  cgap_back #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_stat.empty),
    .cmd_in    (q_dout),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // queue cannot be full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // back end only takes a command that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a push into a full queue would lose a request
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

### sv/cgap_front.sv
// ----------------------------------------------------------------------------
// cgap_front
// configuration registers and request classification into queue commands
// ----------------------------------------------------------------------------
`default_nettype none

module cgap_front import cgap_pkg::*; #(
  parameter int MAX_QUBITS  = 16,
  parameter int MAX_TARGETS = 2,
  localparam int AW = MAX_QUBITS,
  localparam int IW = (MAX_QUBITS > 16) ? MAX_QUBITS : 16,
  localparam int CW = 75 + IW + 4 * AW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire req_t          req,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          q_full,
  output logic               push,
  output logic [CW-1:0]      cmd_out
);

  localparam int TL = (MAX_TARGETS < 2) ? MAX_TARGETS : 2;

  typedef struct packed {
    req_kind_t              kind;
    logic                   pass;
    logic [1:0]             last_col;
    logic [1:0]             row;
    logic [3:0]             gaddr;
    logic [IW-1:0]          idx;
    logic [3:0][AW-1:0]     ridx;
    logic signed [31:0]     re;
    logic signed [31:0]     im;
  } cmd_t;

  logic [4:0]  qubit_count;
  logic [1:0]  target_count;
  logic [3:0]  target_first;
  logic [3:0]  target_second;
  logic [15:0] control_mask;
  logic [15:0] anticontrol_mask;

  logic [4:0]    nq;
  logic [IW-1:0] vmask;
  logic [IW-1:0] oh0;
  logic [IW-1:0] oh1;
  logic [IW-1:0] ival;
  logic [IW-1:0] r;
  logic          two_tgt;
  cmd_t          cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count      <= RST_QUBIT_COUNT;
      target_count     <= RST_TARGET_COUNT;
      target_first     <= RST_TARGET_FIRST;
      target_second    <= RST_TARGET_SECOND;
      control_mask     <= '0;
      anticontrol_mask <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_QUBIT_COUNT:      qubit_count      <= cfg_data[4:0];
        CFG_TARGET_COUNT:     target_count     <= cfg_data[1:0];
        CFG_TARGET_FIRST:     target_first     <= cfg_data[3:0];
        CFG_TARGET_SECOND:    target_second    <= cfg_data[3:0];
        CFG_CONTROL_MASK:     control_mask     <= cfg_data;
        CFG_ANTICONTROL_MASK: anticontrol_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    if (qubit_count == 5'd0) begin
      nq = 5'd1;
    end else if (qubit_count > 5'(MAX_QUBITS)) begin
      nq = 5'(MAX_QUBITS);
    end else begin
      nq = qubit_count;
    end
    for (int b = 0; b < IW; b++) begin
      vmask[b] = (5'(b) < nq);
    end
    two_tgt = (target_count >= 2'd2) && (TL >= 2);
    oh0     = IW'(1) << target_first;
    oh1     = IW'(1) << target_second;
    ival    = IW'(req.amp_index) & vmask;

    cmd.kind  = req.req_type;
    cmd.pass  = ((ival[15:0] & control_mask) != control_mask) ||
                ((ival[15:0] & anticontrol_mask) != 16'd0);
    cmd.row   = {two_tgt & (|(ival & oh1)), |(ival & oh0)};
    cmd.gaddr = {req.matrix_row, req.matrix_col};
    cmd.re    = req.value_re;
    cmd.im    = req.value_im;
    cmd.idx   = (req.req_type == REQ_COMPUTE) ? ival : IW'(req.amp_index);
    if (cmd.pass) begin
      cmd.last_col = 2'd0;
    end else if (two_tgt) begin
      cmd.last_col = 2'd3;
    end else begin
      cmd.last_col = 2'd1;
    end

    // index with target bits replaced by the column bits, the second target wins
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r = ival;
      r = ((c & 1) != 0) ? (r | oh0) : (r & ~oh0);
      if (two_tgt) begin
        r = ((c & 2) != 0) ? (r | oh1) : (r & ~oh1);
      end
      r = r & vmask;
      cmd.ridx[c] = r[AW-1:0];
    end
    if (cmd.pass) begin
      cmd.ridx[0] = ival[AW-1:0];
    end
  end

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;
  assign cmd_out   = cmd;

endmodule

`default_nettype wire

### sv/cgap_fifo.sv
// ----------------------------------------------------------------------------
// cgap_fifo
// two entry command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cgap_fifo import cgap_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output q_stat_t           stat
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign dout       = slots[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

`default_nettype wire

### sv/cgap_back.sv
// ----------------------------------------------------------------------------
// cgap_back
// amplitude store, gate store, complex multiply-accumulate and norm
// ----------------------------------------------------------------------------
`default_nettype none

module cgap_back import cgap_pkg::*; #(
  parameter int MAX_QUBITS = 16,
  localparam int AW = MAX_QUBITS,
  localparam int IW = (MAX_QUBITS > 16) ? MAX_QUBITS : 16,
  localparam int CW = 75 + IW + 4 * AW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire logic [CW-1:0] cmd_in,
  output logic               pop,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rsp_t               rsp
);

  typedef struct packed {
    req_kind_t              kind;
    logic                   pass;
    logic [1:0]             last_col;
    logic [1:0]             row;
    logic [3:0]             gaddr;
    logic [IW-1:0]          idx;
    logic [3:0][AW-1:0]     ridx;
    logic signed [31:0]     re;
    logic signed [31:0]     im;
  } cmd_t;

  function automatic logic signed [31:0] sat_round(input logic signed [66:0] a);
    logic signed [66:0] t;
    logic signed [66:0] q;
    t = a + (67'sd1 <<< 29);
    q = t >>> 30;
    if (q > 67'sh7FFF_FFFF) begin
      sat_round = 32'sh7FFF_FFFF;
    end else if (q < -67'sh8000_0000) begin
      sat_round = 32'sh8000_0000;
    end else begin
      sat_round = q[31:0];
    end
  endfunction

  back_state_t state, state_next;

  cmd_t cin;
  cmd_t cmd;

  logic [63:0] amp_mem [2**AW];
  logic [63:0] gate_mem [16];

  logic [1:0]  col;
  logic        issue;
  logic        finish;
  logic        out_free;
  logic        rd_vld;
  logic        mul_vld;
  logic [63:0] mem_q;
  logic [63:0] gate_q;

  logic signed [31:0] ar, ai, gr, gi;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [66:0] acc_re, acc_im;
  logic signed [31:0] res_re, res_im;
  logic [63:0]        sq_re, sq_im;
  logic [63:0]        sq_sum;
  logic [64:0]        norm_tot;
  logic [62:0]        norm_acc;
  logic [62:0]        norm_new;

  assign cin      = cmd_in;
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (!q_empty && cin.kind == REQ_COMPUTE) state_next = B_ISSUE;
      B_ISSUE:  if (col == cmd.last_col) state_next = B_DRAIN;
      B_DRAIN:  if (!rd_vld && !mul_vld) state_next = B_ROUND;
      B_ROUND:  state_next = B_SQUARE;
      B_SQUARE: state_next = B_NORM;
      B_NORM:   if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop    = (state == B_IDLE) && !q_empty;
    issue  = (state == B_ISSUE);
    finish = (state == B_NORM) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (pop && cin.kind == REQ_LOAD_AMP) begin
      amp_mem[cin.idx[AW-1:0]] <= {cin.im, cin.re};
    end
    if (issue) begin
      mem_q <= amp_mem[cmd.ridx[col]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cin.kind == REQ_LOAD_GATE) begin
      gate_mem[cin.gaddr] <= {cin.im, cin.re};
    end
    if (issue) begin
      gate_q <= gate_mem[{cmd.row, col}];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= cin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= 2'd0;
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      if (pop) begin
        col <= 2'd0;
      end else if (issue) begin
        col <= col + 2'd1;
      end
      rd_vld  <= issue;
      mul_vld <= rd_vld;
    end
  end

  // pass-through multiplies the old amplitude by one
  assign ar = mem_q[31:0];
  assign ai = mem_q[63:32];
  assign gr = cmd.pass ? GATE_ONE : gate_q[31:0];
  assign gi = cmd.pass ? 32'sd0 : gate_q[63:32];

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      p_rr <= ar * gr;
      p_ii <= ai * gi;
      p_ri <= ar * gi;
      p_ir <= ai * gr;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (mul_vld) begin
      acc_re <= acc_re + 67'(p_rr) - 67'(p_ii);
      acc_im <= acc_im + 67'(p_ri) + 67'(p_ir);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_ROUND) begin
      res_re <= sat_round(acc_re);
      res_im <= sat_round(acc_im);
    end
    if (state == B_SQUARE) begin
      sq_re <= $unsigned(64'(res_re) * 64'(res_re));
      sq_im <= $unsigned(64'(res_im) * 64'(res_im));
    end
  end

  always_comb begin
    sq_sum   = sq_re + sq_im;
    norm_tot = 65'(norm_acc) + 65'(sq_sum);
    norm_new = (norm_tot > 65'(NORM_MAX)) ? NORM_MAX : norm_tot[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_acc <= '0;
    end else if (pop && cin.kind == REQ_CLEAR_NORM) begin
      norm_acc <= '0;
    end else if (finish) begin
      norm_acc <= norm_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.out_index      <= cmd.idx[15:0];
      rsp.out_re         <= res_re;
      rsp.out_im         <= res_im;
      rsp.passed_through <= cmd.pass;
      rsp.norm_sum       <= norm_new;
    end
  end

endmodule

`default_nettype wire

### tb/sv/gate_result_checker.sv
// ----------------------------------------------------------------------------
// gate_result_checker
// watches the request, result and config channels of the controlled gate
// application core, predicts each compute result and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module gate_result_checker import cgap_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_ready,
  input  wire req_t        req,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_ready,
  input  wire rsp_t        rsp,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               computes_seen,
  output int               passes_seen
);

  localparam logic signed [71:0] HALF_LSB = 72'sd536870912;
  localparam logic signed [71:0] Q_MAX    = 72'sd2147483647;
  localparam logic signed [71:0] Q_MIN    = -72'sd2147483648;

  logic [63:0] amp_store [65536];
  logic [63:0] gate_store [16];
  logic [62:0] norm_acc;
  logic [4:0]  qubits;
  logic [1:0]  targets;
  logic [3:0]  tgt0, tgt1;
  logic [15:0] ctrl_mask, anti_mask;
  rsp_t        amp_results_due[$];

  initial begin
    foreach (amp_store[k]) amp_store[k] = '0;
    foreach (gate_store[k]) gate_store[k] = '0;
    fail_count = 0;
    computes_seen = 0;
    passes_seen = 0;
  end

  function automatic logic signed [31:0] round_sat(logic signed [71:0] s);
    logic signed [71:0] t;
    t = (s + HALF_LSB) >>> 30;
    if (t > Q_MAX) t = Q_MAX;
    if (t < Q_MIN) t = Q_MIN;
    return t[31:0];
  endfunction

  // new amplitude for one compute request, updates the norm accumulator
  function automatic rsp_t predict_amplitude(req_t r);
    rsp_t               o;
    int                 nq, tc;
    logic [15:0]        vmask, i, ridx;
    logic [3:0]         tpos [2];
    logic [1:0]         row;
    logic signed [31:0] ar, ai, gr, gi, re, im;
    logic signed [71:0] sum_re, sum_im;
    logic [65:0]        sq;
    logic               pass;
    nq = (qubits == 0) ? 1 : ((qubits > 16) ? 16 : int'(qubits));
    tc = (targets == 0) ? 1 : ((targets > 2) ? 2 : int'(targets));
    vmask = 16'((17'd1 << nq) - 1);
    i = r.amp_index & vmask;
    tpos[0] = tgt0;
    tpos[1] = tgt1;
    pass = ((i & ctrl_mask) != ctrl_mask) || ((i & anti_mask) != 0);
    if (pass) begin
      re = amp_store[i][31:0];
      im = amp_store[i][63:32];
    end else begin
      sum_re = '0;
      sum_im = '0;
      row = '0;
      for (int k = 0; k < tc; k++) row[k] = i[tpos[k]];
      for (int col = 0; col < (1 << tc); col++) begin
        ridx = i;
        for (int k = 0; k < tc; k++) ridx[tpos[k]] = col[k];
        ridx &= vmask;
        ar = amp_store[ridx][31:0];
        ai = amp_store[ridx][63:32];
        gr = gate_store[{row, 2'(col)}][31:0];
        gi = gate_store[{row, 2'(col)}][63:32];
        sum_re = sum_re + ar * gr - ai * gi;
        sum_im = sum_im + ar * gi + ai * gr;
      end
      re = round_sat(sum_re);
      im = round_sat(sum_im);
    end
    sq = 66'(64'(re) * 64'(re)) + 66'(64'(im) * 64'(im));
    if (sq > 66'(NORM_MAX) - 66'(norm_acc)) norm_acc = NORM_MAX;
    else norm_acc = norm_acc + 63'(sq);
    o.out_index = i;
    o.out_re = re;
    o.out_im = im;
    o.passed_through = pass;
    o.norm_sum = norm_acc;
    return o;
  endfunction

  assign pending = amp_results_due.size();

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      norm_acc <= '0;
      qubits <= RST_QUBIT_COUNT;
      targets <= RST_TARGET_COUNT;
      tgt0 <= RST_TARGET_FIRST;
      tgt1 <= RST_TARGET_SECOND;
      ctrl_mask <= '0;
      anti_mask <= '0;
      amp_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_QUBIT_COUNT:      qubits <= cfg_data[4:0];
          CFG_TARGET_COUNT:     targets <= cfg_data[1:0];
          CFG_TARGET_FIRST:     tgt0 <= cfg_data[3:0];
          CFG_TARGET_SECOND:    tgt1 <= cfg_data[3:0];
          CFG_CONTROL_MASK:     ctrl_mask <= cfg_data;
          CFG_ANTICONTROL_MASK: anti_mask <= cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        case (req.req_type)
          REQ_LOAD_AMP:   amp_store[req.amp_index] = {req.value_im, req.value_re};
          REQ_LOAD_GATE:  gate_store[{req.matrix_row, req.matrix_col}] =
                            {req.value_im, req.value_re};
          REQ_CLEAR_NORM: norm_acc = '0;
          REQ_COMPUTE: begin
            exp_r = predict_amplitude(req);
            amp_results_due.push_back(exp_r);
          end
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (amp_results_due.size() == 0) begin
          $error("result with no request waiting: index %0h", rsp.out_index);
          fail_count++;
        end else begin
          exp_r = amp_results_due.pop_front();
          computes_seen++;
          if (exp_r.passed_through) passes_seen++;
          if (rsp.out_index !== exp_r.out_index) begin
            $error("out_index expected %0h got %0h", exp_r.out_index, rsp.out_index);
            fail_count++;
          end
          if (rsp.out_re !== exp_r.out_re) begin
            $error("out_re expected %0d got %0d", exp_r.out_re, rsp.out_re);
            fail_count++;
          end
          if (rsp.out_im !== exp_r.out_im) begin
            $error("out_im expected %0d got %0d", exp_r.out_im, rsp.out_im);
            fail_count++;
          end
          if (rsp.passed_through !== exp_r.passed_through) begin
            $error("passed_through expected %0b got %0b", exp_r.passed_through,
                   rsp.passed_through);
            fail_count++;
          end
          if (rsp.norm_sum !== exp_r.norm_sum) begin
            $error("norm_sum expected %0h got %0h", exp_r.norm_sum, rsp.norm_sum);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the controlled gate application core: directed
// extremes, then phases of random loads and computes under several register
// settings, with random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import cgap_pkg::*;;

  logic        clk;
  logic        rst;
  logic        req_valid, req_ready;
  req_t        req;
  logic        rsp_valid, rsp_ready;
  rsp_t        rsp;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count, pending, computes_seen, passes_seen;

  // no idling at all in the closing phase
  bit quiet;
  int stall_left;
  int requests_sent;

  // mirror of the register settings, used only to keep reads on written entries
  int qc, tcnt, t0, t1, cmask, amask;
  bit amp_written [65536];
  bit gate_written [16];

  controlled_gate_application_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gate_result_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .computes_seen(computes_seen), .passes_seen(passes_seen)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // amplitude or gate value: extremes, small magnitudes or any pattern
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom) >>> $urandom_range(2, 12));
      5: return GATE_ONE;
      default: return $urandom;
    endcase
  endfunction

  // one request; valid is only dropped when an idle burst follows
  task automatic send_request(req_kind_t kind, logic [15:0] idx, logic [1:0] mrow,
                              logic [1:0] mcol, logic [31:0] vre, logic [31:0] vim);
    req_t r;
    r.req_type = kind;
    r.amp_index = idx;
    r.matrix_row = mrow;
    r.matrix_col = mcol;
    r.value_re = vre;
    r.value_im = vim;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    requests_sent++;
    if (kind == REQ_LOAD_AMP) amp_written[idx] = 1'b1;
    if (kind == REQ_LOAD_GATE) gate_written[{mrow, mcol}] = 1'b1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_amp(logic [15:0] idx);
    send_request(REQ_LOAD_AMP, idx, 2'($urandom), 2'($urandom), pick_value(), pick_value());
  endtask

  // compute at raw index, first loading any entry it would read unwritten
  task automatic compute_at(logic [15:0] raw);
    int          nq, tc;
    logic [15:0] vmask, i, ridx;
    logic [1:0]  row;
    logic [3:0]  tpos [2];
    bit          pass;
    nq = (qc == 0) ? 1 : ((qc > 16) ? 16 : qc);
    tc = (tcnt == 0) ? 1 : ((tcnt > 2) ? 2 : tcnt);
    vmask = 16'((17'd1 << nq) - 1);
    i = raw & vmask;
    tpos[0] = 4'(t0);
    tpos[1] = 4'(t1);
    pass = ((i & 16'(cmask)) != 16'(cmask)) || ((i & 16'(amask)) != 0);
    if (pass) begin
      if (!amp_written[i]) load_amp(i);
    end else begin
      row = '0;
      for (int k = 0; k < tc; k++) row[k] = i[tpos[k]];
      for (int col = 0; col < (1 << tc); col++) begin
        ridx = i;
        for (int k = 0; k < tc; k++) ridx[tpos[k]] = col[k];
        ridx &= vmask;
        if (!amp_written[ridx]) load_amp(ridx);
        if (!gate_written[{row, 2'(col)}])
          send_request(REQ_LOAD_GATE, 16'($urandom), row, 2'(col), pick_value(),
                       pick_value());
      end
    end
    send_request(REQ_COMPUTE, raw, 2'($urandom), 2'($urandom), $urandom, $urandom);
  endtask

  // wait until all results are in and loads have drained from the queue
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // all six registers, only called while the core is idle
  task automatic write_config(int nq, int tc, int f0, int f1, int cm, int am);
    int vals [6];
    vals = '{nq, tc, f0, f1, cm, am};
    for (int k = 0; k < 6; k++) begin
      cfg_index <= 3'(k);
      cfg_data <= 16'(vals[k]);
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    qc = nq; tcnt = tc; t0 = f0; t1 = f1; cmask = cm; amask = am;
  endtask

  task automatic random_phase(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) compute_at(16'($urandom));
      else if (pick < 16) load_amp(16'($urandom));
      else if (pick < 19)
        send_request(REQ_LOAD_GATE, 16'($urandom), 2'($urandom), 2'($urandom),
                     pick_value(), pick_value());
      else
        send_request(REQ_CLEAR_NORM, 16'($urandom), 2'($urandom), 2'($urandom),
                     $urandom, $urandom);
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rsp_ready <= 1'b0;
    stall_left = 0;
    quiet = 1'b0;
    requests_sent = 0;
    qc = 16; tcnt = 1; t0 = 0; t1 = 1; cmask = 0; amask = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extreme gate entries and amplitudes,
    // saturating products, norm clear and top index
    send_request(REQ_LOAD_GATE, 16'h0, 2'd0, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(REQ_LOAD_GATE, 16'h0, 2'd0, 2'd1, GATE_ONE, 32'h0);
    send_request(REQ_LOAD_GATE, 16'h0, 2'd1, 2'd0, 32'h8000_0000, 32'h8000_0000);
    send_request(REQ_LOAD_GATE, 16'h0, 2'd1, 2'd1, 32'h0, GATE_ONE);
    send_request(REQ_LOAD_AMP, 16'h0000, 2'd3, 2'd3, 32'h8000_0000, 32'h8000_0000);
    send_request(REQ_LOAD_AMP, 16'h0001, 2'd0, 2'd0, 32'h7FFF_FFFF, 32'h0);
    send_request(REQ_LOAD_AMP, 16'hFFFF, 2'd0, 2'd0, 32'h0, 32'h7FFF_FFFF);
    send_request(REQ_LOAD_AMP, 16'hFFFE, 2'd0, 2'd0, 32'h0000_0001, 32'hFFFF_FFFF);
    compute_at(16'h0000);
    compute_at(16'h0001);
    compute_at(16'hFFFF);
    compute_at(16'hFFFE);
    send_request(REQ_CLEAR_NORM, 16'hFFFF, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    compute_at(16'h0000);
    compute_at(16'h0000);
    wait_idle();

    // settings: two targets far apart, the smallest state, out of range
    // counts, equal targets, controls and anticontrols at their extremes
    write_config(16, 2, 0, 15, 0, 0);      random_phase(160); wait_idle();
    write_config(1, 1, 0, 3, 0, 0);        random_phase(120); wait_idle();
    write_config(0, 0, 15, 14, 0, 0);      random_phase(100); wait_idle();
    write_config(31, 3, 5, 5, 3, 0);       random_phase(160); wait_idle();
    write_config(4, 2, 3, 0, 4, 2);        random_phase(160); wait_idle();
    write_config(16, 1, 15, 2, 65535, 0);  random_phase(120); wait_idle();
    write_config(16, 2, 7, 9, 0, 65535);   random_phase(120); wait_idle();
    for (int p = 0; p < 3; p++) begin
      write_config($urandom_range(0, 31), $urandom_range(0, 3), $urandom_range(0, 15),
                   $urandom_range(0, 15), 1 << $urandom_range(0, 15),
                   $urandom_range(0, 1) << $urandom_range(0, 15));
      random_phase(140);
      wait_idle();
    end
    write_config(12, 2, 11, 4, 0, 1);
    quiet = 1'b1;
    random_phase(140);
    wait_idle();

    $display("covered %0d requests, %0d results, %0d passed through",
             requests_sent, computes_seen, passes_seen);
    $display("twelve register settings incl. out of range counts and equal targets");
    if (fail_count == 0 && pending == 0) begin
      $display("controlled_gate_application_core verification clean");
    end else begin
      $display("controlled_gate_application_core verification failed");
    end
    $finish;
  end

  // generous overall limit
  initial begin
    #3000000;
    $display("controlled_gate_application_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/cgap_pkg.sv
sv/cgap_front.sv
sv/cgap_fifo.sv
sv/cgap_back.sv
sv/controlled_gate_application_core.sv
tb/sv/gate_result_checker.sv
tb/sv/tb_top.sv
